FILE: hw/rtl/u16u8_pkg.sv
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by every module of the block.
package u16u8_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned MaxBytes = 6;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  // One queue entry: all UTF-8 bytes that one accepted unit releases.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;     // bytes[0] goes out first
    logic [2:0]               cnt;       // 1..6
    logic                     text_end;  // item carried last_unit
  } entry_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  // Encode one code point (up to 21 bits) into 1 to 4 UTF-8 bytes.
  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.b[0] = {1'b0, cp[6:0]};
      e.n    = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.n    = 3'd2;
    end else if (cp < SuppBase) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.n    = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.n    = 3'd4;
    end
    return e;
  endfunction

endpackage

FILE: hw/rtl/utf16_to_utf8_transcoder_unit.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, entry queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Usage:
//   Input side is a queue write port: drive code_unit_i and last_unit_i with
//   push high; the unit transfers on a clock edge where full is low.
//   Output side is a queue read port: while empty is low, out_byte_o,
//   run_last_o and text_end_o show the oldest UTF-8 byte; it transfers on an
//   edge where pop is high.
//   A high surrogate not marked last is held inside and releases nothing
//   until the next unit arrives; every other unit releases 1 to 6 bytes.
// Path: the first byte of a unit is written into a queue entry and then loaded
//   into the output register when the output side is free.
// Throughput: one unit per cycle while each unit makes one byte and pop is high; the
//   back end moves one byte per cycle, so a unit of N bytes occupies it until its N bytes are out.
//   The four-entry queue absorbs bursts of multi-byte units.
// Reset: clears the held surrogate, the queue and the output valid flag.
// Stall: when pop stays low the output byte holds, the queue fills and
//   full rises once it holds four entries.
module utf16_to_utf8_transcoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        text_end_o
);

  logic              accept;
  logic              q_full, q_empty, q_wr, q_rd;
  logic              held_valid;
  u16u8_pkg::entry_t q_wdata, q_rdata;

  // Transfer a unit in only when the queue has room for its bytes.
  assign accept = push && !q_full;
  assign full   = q_full;

  // Classify and encode; hold a pending high surrogate.
  u16u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .code_unit_i   (code_unit_i),
    .last_unit_i   (last_unit_i),
    .entry_valid_o (q_wr),
    .entry_o       (q_wdata),
    .held_valid_o  (held_valid)
  );

  // Decouple the front end from the byte serializer.
  u16u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Advance one byte per cycle into the output register while it is empty or popped.
  u16u8_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_rdata),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .text_end_o (text_end_o)
  );

`ifndef SYNTHESIS
  // The string end always closes the run of its unit.
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && text_end_o) |-> run_last_o)
    else $error("text_end without run_last");

  // A unit marked last never leaves a surrogate held.
  a_last_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_unit_i) |=> !held_valid)
    else $error("surrogate held after last unit");

  // Entries only retire from a non-empty queue with a defined byte count.
  a_retire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> (!q_empty && q_rdata.cnt != 3'd0))
    else $error("queue read with no valid entry");
`endif

endmodule

FILE: hw/rtl/u16u8_front.sv
// Front end: classifies each code unit, pairs surrogates and encodes the bytes.
// Depends on u16u8_pkg.
module u16u8_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [15:0]          code_unit_i,
  input  logic                 last_unit_i,
  output logic                 entry_valid_o,
  output u16u8_pkg::entry_t    entry_o,
  output logic                 held_valid_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;

  logic              is_high, is_low, hold_new;
  logic [20:0]       pair_cp;
  u16u8_pkg::enc_t   enc_unit, enc_held, enc_pair;
  u16u8_pkg::entry_t entry;

  assign is_high  = (code_unit_i >= u16u8_pkg::HighFirst) &&
                    (code_unit_i <= u16u8_pkg::HighLast);
  assign is_low   = (code_unit_i >= u16u8_pkg::LowFirst) &&
                    (code_unit_i <= u16u8_pkg::LowLast);
  assign hold_new = is_high && !last_unit_i;
  assign pair_cp  = u16u8_pkg::SuppBase + {1'b0, held_bits_q, code_unit_i[9:0]};

  assign enc_unit = u16u8_pkg::encode_cp({5'b0, code_unit_i});
  assign enc_held = u16u8_pkg::encode_cp({5'b0, 6'b110110, held_bits_q});
  assign enc_pair = u16u8_pkg::encode_cp(pair_cp);

  always_comb begin
    entry          = '0;
    entry.text_end = last_unit_i;
    if (held_valid_q && is_low) begin
      entry.bytes[3:0] = enc_pair.b;
      entry.cnt        = enc_pair.n;
    end else if (held_valid_q) begin
      // Flush the stale high surrogate, then append the new unit unless it is held.
      entry.bytes[2:0] = enc_held.b[2:0];
      entry.cnt        = 3'd3;
      if (!hold_new) begin
        entry.bytes[5:3] = enc_unit.b[2:0];
        entry.cnt        = 3'd3 + enc_unit.n;
      end
    end else if (!hold_new) begin
      entry.bytes[3:0] = enc_unit.b;
      entry.cnt        = enc_unit.n;
    end
  end

  always_comb begin
    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    if (accept_i) begin
      held_valid_d = hold_new;
      held_bits_d  = code_unit_i[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

  assign entry_valid_o = accept_i && (entry.cnt != 3'd0);
  assign entry_o       = entry;
  assign held_valid_o  = held_valid_q;

endmodule

FILE: hw/rtl/u16u8_queue.sv
// Short entry queue between front and back end.
// Depends on u16u8_pkg.
module u16u8_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  u16u8_pkg::entry_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output u16u8_pkg::entry_t rdata_o,
  output logic              empty_o
);

  u16u8_pkg::entry_t mem_q [u16u8_pkg::QDepth];
  logic [u16u8_pkg::QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [u16u8_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == u16u8_pkg::QCntW'(u16u8_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == u16u8_pkg::QPtrW'(u16u8_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == u16u8_pkg::QPtrW'(u16u8_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/u16u8_back.sv
// Back end: walks the bytes of the head entry into the output register.
// Depends on u16u8_pkg.
module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  u16u8_pkg::entry_t q_head_i,
  output logic              q_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              text_end_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       text_end_q, text_end_d;
  logic       load, is_final;
  logic [7:0] sel_byte;

  assign load     = !q_empty_i && (!out_valid_q || pop_i);
  assign is_final = ((idx_q + 3'd1) == q_head_i.cnt);

  always_comb begin
    case (idx_q)
      3'd0:    sel_byte = q_head_i.bytes[0];
      3'd1:    sel_byte = q_head_i.bytes[1];
      3'd2:    sel_byte = q_head_i.bytes[2];
      3'd3:    sel_byte = q_head_i.bytes[3];
      3'd4:    sel_byte = q_head_i.bytes[4];
      3'd5:    sel_byte = q_head_i.bytes[5];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    text_end_d  = text_end_q;
    if (load) begin
      out_valid_d = 1'b1;
      byte_d      = sel_byte;
      run_last_d  = is_final;
      text_end_d  = is_final && q_head_i.text_end;
      idx_d       = is_final ? 3'd0 : idx_q + 3'd1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    text_end_q <= text_end_d;
  end

  assign q_rd_o     = load && is_final;
  assign empty_o    = !out_valid_q;
  assign out_byte_o = byte_q;
  assign run_last_o = run_last_q;
  assign text_end_o = text_end_q;

endmodule
